// ===== design/cifq_pkg.sv =====
// ----------------------------------------------------------------------------
// cifq_pkg
// Shared types and constants for the claim/fill in-order completion queue.
// ----------------------------------------------------------------------------
package cifq_pkg;

   localparam int MAX_SLOTS    = 16;
   localparam int SLOT_BITS    = $clog2(MAX_SLOTS);
   localparam int RING_BITS    = SLOT_BITS + 1;
   localparam int PAYLOAD_BITS = 32;

   localparam logic [RING_BITS-1:0] RING_MIN   = RING_BITS'(2);
   localparam logic [RING_BITS-1:0] RING_MAX   = RING_BITS'(MAX_SLOTS);
   localparam logic [RING_BITS-1:0] RING_RESET = RING_BITS'(16);

   // Operation codes carried in the request
   typedef enum logic [1:0] {
      MODE_CLAIM = 2'd0,
      MODE_PUSH  = 2'd1,
      MODE_POP   = 2'd2,
      MODE_NOP   = 2'd3
   } mode_type;

   // Result status codes
   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_FULL    = 3'd1,
      ST_EMPTY   = 3'd2,
      ST_IGNORED = 3'd3,
      ST_DOUBLE  = 3'd4
   } status_type;

   typedef struct packed {
      logic [1:0]              mode;
      logic [SLOT_BITS-1:0]    slot_index;
      logic                    token_live;
      logic [PAYLOAD_BITS-1:0] data_in;
   } req_type;

   typedef struct packed {
      logic [2:0]              status;
      logic [SLOT_BITS-1:0]    claimed_slot;
      logic [PAYLOAD_BITS-1:0] data_out;
      logic                    any_filled;
   } rsp_type;

   // Ring pointers and the ring size in force
   typedef struct packed {
      logic [SLOT_BITS-1:0] producer;
      logic [SLOT_BITS-1:0] consumer;
      logic [RING_BITS-1:0] ring_n;
   } ring_state_type;

endpackage

// ===== design/cifq_ram.sv =====
// ----------------------------------------------------------------------------
// cifq_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cifq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cifq_region.sv =====
// ----------------------------------------------------------------------------
// cifq_region
// Flags whether any filled slot lies in the live region of the ring, walking
// from the consumer pointer up to the producer pointer.
// ----------------------------------------------------------------------------
module cifq_region import cifq_pkg::*; (
   input  ring_state_type       ring,
   input  logic [MAX_SLOTS-1:0] filled,
   output logic                 any_filled
);

   logic [MAX_SLOTS-1:0] live_mask;

   // Build the live-region mask, one slot at a time
   always_comb begin
      logic [RING_BITS-1:0] idx;
      logic [RING_BITS-1:0] c;
      logic [RING_BITS-1:0] p;
      c = {1'b0, ring.consumer};
      p = {1'b0, ring.producer};
      idx = '0;
      live_mask = '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
         idx = RING_BITS'(i);
         if (c == p) begin
            live_mask[i] = 1'b0;
         end else if (c >= ring.ring_n) begin
            // Consumer past the end: its own slot, then wrap to zero
            live_mask[i] = (idx == c) || (idx < p && idx < ring.ring_n);
         end else if (p >= ring.ring_n) begin
            // Producer never reached: the walk covers the whole ring
            live_mask[i] = (idx < ring.ring_n);
         end else if (c < p) begin
            live_mask[i] = (idx >= c) && (idx < p);
         end else begin
            live_mask[i] = ((idx >= c) && (idx < ring.ring_n)) || (idx < p);
         end
      end
   end

   assign any_filled = |(live_mask & filled);

endmodule

// ===== design/claim_fill_inorder_queue.sv =====
// ----------------------------------------------------------------------------
// claim_fill_inorder_queue
// Reorder-buffer style completion ring: claim a slot, fill it in any order,
// pop filled slots in claim order.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data and raise start; the request transfers
//   on a rising edge with start high and busy low. Requests may follow on
//   every cycle, one item per clock.
//   Response channel: exactly one result per request, shown on rsp_data for
//   one cycle with rsp_valid high, in the cycle right after the request
//   transfer. The receiver cannot stall; it must take the result
//   in that cycle.
//   The payload comes from the registered read of the payload RAM, which a
//   pop reads at the transfer edge. Slot fill flags and both ring pointers
//   live in flip-flops and are updated at the transfer edge.
//   Configuration: csr_data is the ring size, written when csr_valid and
//   csr_ready are high; write it only while no request is outstanding.
//   Reset: synchronous; empties the ring, zeroes both pointers, sets the
//   ring size to 16 and holds busy high until the first edge with reset low.
// ----------------------------------------------------------------------------
module claim_fill_inorder_queue import cifq_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   // response channel
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   // configuration channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [RING_BITS-1:0] csr_data
);

   logic                    busy_ff;
   logic [RING_BITS-1:0]    ring_size_ff;
   logic [SLOT_BITS-1:0]    producer_ff, producer_in;
   logic [SLOT_BITS-1:0]    consumer_ff, consumer_in;
   logic [MAX_SLOTS-1:0]    filled_ff, filled_in;
   logic                    rsp_valid_ff;
   status_type              status_ff, status_in;
   logic [SLOT_BITS-1:0]    claimed_ff, claimed_in;
   logic                    pop_ok_ff, pop_ok_in;

   logic                    accept;
   logic [RING_BITS-1:0]    ring_n;
   logic [SLOT_BITS-1:0]    prod_next;
   logic [SLOT_BITS-1:0]    cons_next;
   logic                    ram_wr_en;
   logic                    ram_rd_en;
   logic [PAYLOAD_BITS-1:0] ram_rd_data;
   ring_state_type          ring;
   logic                    any_filled;

   assign accept    = start && !busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = !busy_ff;

   // Clamp the ring size to the supported range
   always_comb begin
      if (ring_size_ff < RING_MIN) begin
         ring_n = RING_MIN;
      end else if (ring_size_ff > RING_MAX) begin
         ring_n = RING_MAX;
      end else begin
         ring_n = ring_size_ff;
      end
   end

   // Next positions of both pointers, wrapping at the ring size
   always_comb begin
      logic [RING_BITS-1:0] p_inc;
      logic [RING_BITS-1:0] c_inc;
      p_inc = {1'b0, producer_ff} + RING_BITS'(1);
      c_inc = {1'b0, consumer_ff} + RING_BITS'(1);
      prod_next = (p_inc >= ring_n) ? '0 : p_inc[SLOT_BITS-1:0];
      cons_next = (c_inc >= ring_n) ? '0 : c_inc[SLOT_BITS-1:0];
   end

   // Decode the request and form the next state
   always_comb begin
      producer_in = producer_ff;
      consumer_in = consumer_ff;
      filled_in   = filled_ff;
      status_in   = ST_OK;
      claimed_in  = '0;
      pop_ok_in   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      if (accept) begin
         case (mode_type'(req_data.mode))
            MODE_CLAIM: begin
               if (prod_next == consumer_ff) begin
                  status_in = ST_FULL;
               end else begin
                  claimed_in  = producer_ff;
                  producer_in = prod_next;
               end
            end
            MODE_PUSH: begin
               if (!req_data.token_live || {1'b0, req_data.slot_index} >= ring_n) begin
                  status_in = ST_IGNORED;
               end else if (filled_ff[req_data.slot_index]) begin
                  status_in = ST_DOUBLE;
               end else begin
                  filled_in[req_data.slot_index] = 1'b1;
                  ram_wr_en = 1'b1;
               end
            end
            MODE_POP: begin
               if (!filled_ff[consumer_ff]) begin
                  status_in = ST_EMPTY;
               end else begin
                  filled_in[consumer_ff] = 1'b0;
                  consumer_in = cons_next;
                  pop_ok_in   = 1'b1;
                  ram_rd_en   = 1'b1;
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         ring_size_ff <= RING_RESET;
         producer_ff  <= '0;
         consumer_ff  <= '0;
         filled_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         producer_ff  <= producer_in;
         consumer_ff  <= consumer_in;
         filled_ff    <= filled_in;
         rsp_valid_ff <= accept;
         if (csr_valid && csr_ready) begin
            ring_size_ff <= csr_data;
         end
      end
   end

   // Result fields, held for the response cycle
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      claimed_ff <= claimed_in;
      pop_ok_ff  <= pop_ok_in;
   end

   // Payload store
   cifq_ram #(
      .WIDTH (PAYLOAD_BITS),
      .DEPTH (MAX_SLOTS)
   ) u_payload (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_data.slot_index),
      .wr_data (req_data.data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (consumer_ff),
      .rd_data (ram_rd_data)
   );

   // Live-region check on the state left by the request
   assign ring.producer = producer_ff;
   assign ring.consumer = consumer_ff;
   assign ring.ring_n   = ring_n;

   cifq_region u_region (
      .ring       (ring),
      .filled     (filled_ff),
      .any_filled (any_filled)
   );

   // Drive the response
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.status       = status_ff;
   assign rsp_data.claimed_slot = claimed_ff;
   assign rsp_data.data_out     = pop_ok_ff ? ram_rd_data : '0;
   assign rsp_data.any_filled   = any_filled;

endmodule

// ===== sim/claim_fill_inorder_queue_tb.sv =====
// ----------------------------------------------------------------------------
// claim_fill_inorder_queue_tb
// Self-checking bench for the claim/fill in-order completion ring. Requests
// are driven through the start/busy handshake, a tracker class predicts each
// result from its own copy of the ring, and every strobed result is compared
// field by field. The ring size is rewritten between phases, extremes
// included; random traffic mostly claims, fills in any order and pops.
// ----------------------------------------------------------------------------
module claim_fill_inorder_queue_tb import cifq_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Tracks ring contents and predicts the result of each request
   class ring_tracker;
      bit                    slot_full [MAX_SLOTS];
      bit [PAYLOAD_BITS-1:0] slot_word [MAX_SLOTS];
      int unsigned           producer;
      int unsigned           consumer;
      bit [RING_BITS-1:0]    ring_reg;
      rsp_type               pending_results [$];
      int errors, checked, n_popped, n_full, n_empty, n_ignored, n_double;

      function new();
         foreach (slot_full[i]) slot_full[i] = 1'b0;
         producer = 0;
         consumer = 0;
         ring_reg = RING_RESET;
      endfunction

      function void set_ring_size(bit [RING_BITS-1:0] v);
         ring_reg = v;
      endfunction

      // Clamp the register to the usable range
      function int unsigned slots_in_force();
         if (ring_reg < 2) return 2;
         if (ring_reg > MAX_SLOTS) return MAX_SLOTS;
         return 32'(ring_reg);
      endfunction

      function int unsigned step_index(int unsigned i, int unsigned n);
         return (i + 1 >= n) ? 0 : i + 1;
      endfunction

      // Scan the live region from consumer up to producer for filled slots
      function bit live_has_data(int unsigned n);
         int unsigned i;
         i = consumer;
         for (int s = 0; s < MAX_SLOTS && i != producer; s++) begin
            if (slot_full[i]) return 1'b1;
            i = step_index(i, n);
         end
         return 1'b0;
      endfunction

      function int outstanding();
         return pending_results.size();
      endfunction

      // Apply one accepted request and queue its expected result
      function rsp_type accept_request(req_type r);
         rsp_type     e;
         int unsigned n;
         int unsigned nxt;
         n = slots_in_force();
         e = '0;
         e.status = ST_OK;
         case (r.mode)
            MODE_CLAIM: begin
               nxt = step_index(producer, n);
               if (nxt == consumer) begin
                  e.status = ST_FULL;
               end else begin
                  e.claimed_slot = SLOT_BITS'(producer);
                  producer = nxt;
               end
            end
            MODE_PUSH: begin
               if (!r.token_live || r.slot_index >= n) begin
                  e.status = ST_IGNORED;
               end else if (slot_full[r.slot_index]) begin
                  e.status = ST_DOUBLE;
               end else begin
                  slot_word[r.slot_index] = r.data_in;
                  slot_full[r.slot_index] = 1'b1;
               end
            end
            MODE_POP: begin
               if (!slot_full[consumer]) begin
                  e.status = ST_EMPTY;
               end else begin
                  e.data_out = slot_word[consumer];
                  slot_full[consumer] = 1'b0;
                  consumer = step_index(consumer, n);
               end
            end
            default: ;
         endcase
         e.any_filled = live_has_data(n);
         case (e.status)
            ST_FULL:    n_full++;
            ST_EMPTY:   n_empty++;
            ST_IGNORED: n_ignored++;
            ST_DOUBLE:  n_double++;
            default:    if (r.mode == MODE_POP) n_popped++;
         endcase
         pending_results.push_back(e);
         return e;
      endfunction

      // Compare a strobed result against the oldest prediction
      function void check_response(rsp_type got);
         rsp_type e;
         if (pending_results.size() == 0) begin
            $error("result with no request outstanding: %p", got);
            errors++;
            return;
         end
         e = pending_results.pop_front();
         checked++;
         if (got.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, got.status);
            errors++;
         end
         if (got.claimed_slot !== e.claimed_slot) begin
            $error("claimed_slot: expected %0d, got %0d", e.claimed_slot, got.claimed_slot);
            errors++;
         end
         if (got.data_out !== e.data_out) begin
            $error("data_out: expected %h, got %h", e.data_out, got.data_out);
            errors++;
         end
         if (got.any_filled !== e.any_filled) begin
            $error("any_filled: expected %0b, got %0b", e.any_filled, got.any_filled);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [RING_BITS-1:0] csr_data;

   ring_tracker sb = new();
   logic [SLOT_BITS-1:0] open_slots [$];   // claimed but not yet filled
   int work_done;
   int requests;
   int quiet_left;

   claim_fill_inorder_queue i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_response(rsp_data);
   end

   // Bound the run
   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int open_pos(logic [SLOT_BITS-1:0] slot);
      for (int j = 0; j < open_slots.size(); j++) begin
         if (open_slots[j] == slot) return j;
      end
      return -1;
   endfunction

   // Mostly back to back, some short gaps, a few long ones, and idle-free runs
   function automatic int gap_len();
      int pick;
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         quiet_left = $urandom_range(20, 80);
         return 0;
      end
      if (pick < 55) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Drop start for a number of cycles
   task automatic hold_off(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   // Present one request and wait for its transfer; start stays high afterward
   task automatic send(input req_type r);
      rsp_type e;
      int      pos;
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      e = sb.accept_request(r);
      requests++;
      pos = open_pos(r.slot_index);
      if (r.mode == MODE_CLAIM && e.status == ST_OK && open_pos(e.claimed_slot) < 0)
         open_slots.push_back(e.claimed_slot);
      if (r.mode == MODE_PUSH && (e.status == ST_OK || e.status == ST_DOUBLE) && pos >= 0)
         open_slots.delete(pos);
      if (r.mode != MODE_NOP && e.status != ST_IGNORED) work_done++;
      @(negedge clock);
   endtask

   task automatic directed(input mode_type m, input int slot, input logic live,
                           input logic [PAYLOAD_BITS-1:0] d);
      req_type r;
      r.mode       = m;
      r.slot_index = SLOT_BITS'(slot);
      r.token_live = live;
      r.data_in    = d;
      hold_off(gap_len());
      send(r);
   endtask

   // Drain outstanding results, then write the ring size
   task automatic write_ring(input logic [RING_BITS-1:0] v);
      start <= 1'b0;
      while (sb.outstanding() > 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.set_ring_size(v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Well-formed claim/fill/pop traffic with a share of noise
   task automatic next_request(output req_type r);
      int pick;
      int sel;
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 19);
      r.mode       = MODE_CLAIM;
      r.slot_index = '0;
      r.token_live = 1'b1;
      r.data_in    = (sel == 0) ? '0 : (sel == 1) ? '1 : $urandom();
      if (pick < 30) begin
         r.mode = MODE_CLAIM;
      end else if (pick < 62 && open_slots.size() > 0) begin
         r.mode       = MODE_PUSH;
         r.slot_index = open_slots[$urandom_range(0, open_slots.size() - 1)];
      end else if (pick < 88) begin
         r.mode = MODE_POP;
      end else begin
         r.mode       = 2'($urandom_range(0, 3));
         r.slot_index = SLOT_BITS'($urandom_range(0, MAX_SLOTS - 1));
         r.token_live = 1'($urandom_range(0, 1));
      end
   endtask

   initial begin
      req_type r;
      int      ring_plan [10];
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_data  = '0;
      work_done = 0;
      requests  = 0;
      quiet_left = 0;
      ring_plan = '{2, 16, 0, 1, 31, 17, 4, 9, 0, 0};
      ring_plan[8] = $urandom_range(0, 31);
      ring_plan[9] = $urandom_range(2, 16);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: capacity two, covers full, empty, out-of-order fill,
      // double fill, dead token, slot beyond ring, unclaimed fill and no-op
      write_ring(RING_BITS'(3));
      directed(MODE_POP,   0,  1'b1, '0);
      directed(MODE_PUSH,  0,  1'b0, 32'h1234_5678);
      directed(MODE_PUSH,  3,  1'b1, 32'h0F0F_0F0F);
      directed(MODE_CLAIM, 0,  1'b1, '0);
      directed(MODE_CLAIM, 0,  1'b1, '0);
      directed(MODE_CLAIM, 0,  1'b1, '0);
      directed(MODE_PUSH,  1,  1'b1, '1);
      directed(MODE_POP,   0,  1'b1, '0);
      directed(MODE_PUSH,  0,  1'b1, '0);
      directed(MODE_PUSH,  0,  1'b1, 32'hDEAD_BEEF);
      directed(MODE_POP,   0,  1'b1, '0);
      directed(MODE_POP,   0,  1'b1, '0);
      directed(MODE_PUSH,  2,  1'b1, 32'hA5A5_A5A5);
      directed(MODE_NOP,   15, 1'b1, '1);
      directed(MODE_CLAIM, 0,  1'b1, '0);
      directed(MODE_POP,   0,  1'b1, '0);
      directed(MODE_PUSH,  15, 1'b1, 32'h5A5A_5A5A);

      // Random phases, ring size rewritten each time with the indices kept
      for (int k = 0; k < 10; k++) begin
         write_ring(RING_BITS'(ring_plan[k]));
         work_done = 0;
         while (work_done < 140) begin
            hold_off(gap_len());
            next_request(r);
            send(r);
         end
      end

      // Let the last results arrive
      start <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("Sent %0d requests over 11 ring sizes; checked %0d results.",
               requests, sb.checked);
      $display("Pops with data %0d, empty %0d, refused claims %0d, ignored %0d, double %0d.",
               sb.n_popped, sb.n_empty, sb.n_full, sb.n_ignored, sb.n_double);
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
